[rtl/core/cdr_pkg.sv]
package cdr_pkg;

    localparam int SAMPLE_W         = 32;
    localparam int DIFF_W           = 33;
    localparam int CHANNEL_W        = 6;
    localparam int CC_W             = 7;
    localparam int RCC_W            = 17;
    localparam int MIX_W            = 16;
    localparam int ROMR_W           = 24;
    localparam int FRAC_W           = 16;
    localparam int WRAP_W           = 64;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;
    localparam int MAX_CHANNELS_DEF = 64;

    localparam logic [CC_W-1:0]   CC_RESET   = CC_W'(1);
    localparam logic [RCC_W-1:0]  RCC_RESET  = RCC_W'(65536);
    localparam logic [MIX_W-1:0]  MIX_RESET  = '0;
    localparam logic [ROMR_W-1:0] ROMR_RESET = ROMR_W'(65536);

    typedef struct packed {
        logic [CC_W-1:0]   channel_count;
        logic [RCC_W-1:0]  recip_channel_count;
        logic [MIX_W-1:0]  mix_ratio;
        logic [ROMR_W-1:0] recip_one_minus_ratio;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_CHANNEL_COUNT,
        REG_RECIP_CHANNEL_COUNT,
        REG_MIX_RATIO,
        REG_RECIP_ONE_MINUS_RATIO
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MEAN,
        ST_TERM,
        ST_READ,
        ST_MUL,
        ST_OUT
    } state_t;

endpackage

[rtl/core/cdr_in_if.sv]
interface cdr_in_if;
    import cdr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink (input valid, input sample, input restart, output ready);
endinterface

[rtl/core/cdr_out_if.sv]
interface cdr_out_if;
    import cdr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] corrected_diff;
    logic [CHANNEL_W-1:0]       channel;
    logic                       last;

    modport source (output valid, output corrected_diff, output channel, output last,
                    input ready);
    modport sink (input valid, input corrected_diff, input channel, input last,
                  output ready);
endinterface

[rtl/core/common_mode_diff_remover_top.sv]
// Common-mode difference remover. Samples enter one channel at a time, channel 0 first;
// restart marks channel 0 of a new sequence and drops the stored previous samples. Each
// sample is read from the sample store on accept and written back while accumulating;
// no new sample is taken before that write-back. After the last channel of a time step
// the block forms the scaled mean (mean, then mix term), then for each result reads the
// difference store, multiplies and saturates into the output register, waiting while
// the output stalls; no input is taken meanwhile. The first time step after reset or
// restart only primes the sample store and gives no results. Configure channel_count
// and the matching reciprocals over the register port while the block is idle.
module common_mode_diff_remover_top #(
    parameter int MAX_CHANNELS = cdr_pkg::MAX_CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    cdr_in_if.sink                       in_ch,
    cdr_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdr_pkg::PADDR_W-1:0]  paddr,
    input  logic [cdr_pkg::PDATA_W-1:0]  pwdata,
    output logic [cdr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import cdr_pkg::*;

    cfg_t cfg;

    cdr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cdr_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

[rtl/core/cdr_cfg.sv]
module cdr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cdr_pkg::PADDR_W-1:0]  paddr,
    input  logic [cdr_pkg::PDATA_W-1:0]  pwdata,
    output logic [cdr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output cdr_pkg::cfg_t                cfg
);
    import cdr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_CHANNEL_COUNT:         cfg_next.channel_count = pwdata[CC_W-1:0];
                REG_RECIP_CHANNEL_COUNT:   cfg_next.recip_channel_count = pwdata[RCC_W-1:0];
                REG_MIX_RATIO:             cfg_next.mix_ratio = pwdata[MIX_W-1:0];
                REG_RECIP_ONE_MINUS_RATIO: cfg_next.recip_one_minus_ratio = pwdata[ROMR_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CHANNEL_COUNT:         prdata = PDATA_W'(cfg_reg.channel_count);
            REG_RECIP_CHANNEL_COUNT:   prdata = PDATA_W'(cfg_reg.recip_channel_count);
            REG_MIX_RATIO:             prdata = PDATA_W'(cfg_reg.mix_ratio);
            REG_RECIP_ONE_MINUS_RATIO: prdata = PDATA_W'(cfg_reg.recip_one_minus_ratio);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count         <= CC_RESET;
            cfg_reg.recip_channel_count   <= RCC_RESET;
            cfg_reg.mix_ratio             <= MIX_RESET;
            cfg_reg.recip_one_minus_ratio <= ROMR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/cdr_core.sv]
module cdr_core #(
    parameter int MAX_CHANNELS = cdr_pkg::MAX_CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cdr_pkg::cfg_t cfg,
    cdr_in_if.sink        in_ch,
    cdr_out_if.source     out_ch
);
    import cdr_pkg::*;

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W  = DIFF_W + CH_W + 1;
    localparam int MP_W   = SUM_W + RCC_W + 1;
    localparam int MEAN_W = MP_W - FRAC_W;
    localparam int TP_W   = MEAN_W + MIX_W + 1;
    localparam int NUM_W  = MEAN_W + 1;
    localparam int FP_W   = NUM_W + ROMR_W + 1;
    localparam int V_W    = WRAP_W - FRAC_W;

    localparam logic signed [V_W-1:0] SAT_MAX = V_W'(64'sd2147483647);
    localparam logic signed [V_W-1:0] SAT_MIN = -V_W'(64'sd2147483648);

    // sample and difference stores
    logic signed [SAMPLE_W-1:0] prev_mem [MAX_CHANNELS];
    logic signed [DIFF_W-1:0]   diff_mem [MAX_CHANNELS];

    state_t                     state_reg, state_next;
    logic [CH_W-1:0]            cnt_reg, cnt_next;
    logic [CH_W-1:0]            ch_reg, ch_next;
    logic [CH_W-1:0]            j_reg, j_next;
    logic                       have_prev_reg, have_prev_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] prev_rd_reg;
    logic signed [DIFF_W-1:0]   diff_rd_reg;
    logic signed [MP_W-1:0]     mp_reg, mp_next;
    logic signed [TP_W-1:0]     tp_reg, tp_next;
    logic signed [WRAP_W-1:0]   fp_reg, fp_next;
    logic signed [SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic [CHANNEL_W-1:0]       out_chan_reg, out_chan_next;
    logic                       out_last_reg, out_last_next;

    logic                       in_ready;
    logic                       acc_en;
    logic                       mean_en;
    logic                       term_en;
    logic                       rd_en;
    logic                       mul_en;
    logic                       out_try;

    logic                       accept;
    logic                       out_free;
    logic                       out_load;
    logic [CH_W-1:0]            rd_addr;
    logic [CNT_W-1:0]           n_act;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       step_end;
    logic                       last_res;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [MEAN_W-1:0]   mean;
    logic signed [MEAN_W-1:0]   term;
    logic signed [NUM_W-1:0]    num;
    logic signed [FP_W-1:0]     fp_full;
    logic signed [V_W-1:0]      scaled;

    // effective channel count
    always_comb
    begin
        if (cfg.channel_count == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (int'(cfg.channel_count) > MAX_CHANNELS)
        begin
            n_act = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            n_act = CNT_W'(cfg.channel_count);
        end
    end

    assign accept   = in_ch.valid && in_ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign out_load = out_try && out_free;
    assign rd_addr  = in_ch.restart ? '0 : cnt_reg;
    assign cnt_inc  = CNT_W'(ch_reg) + CNT_W'(1);
    assign step_end = cnt_inc >= n_act;
    assign last_res = (CNT_W'(j_reg) + CNT_W'(1)) == n_act;

    assign diff    = DIFF_W'(sample_reg) - DIFF_W'(prev_rd_reg);
    assign mean    = $signed(mp_reg[MP_W-1:FRAC_W]);
    assign term    = $signed(tp_reg[FRAC_W +: MEAN_W]);
    assign num     = NUM_W'(diff_rd_reg) - NUM_W'(term);
    assign fp_full = num * $signed({1'b0, cfg.recip_one_minus_ratio});
    assign scaled  = $signed(fp_reg[WRAP_W-1:FRAC_W]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (step_end && have_prev_reg)
                begin
                    state_next = ST_MEAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEAN: state_next = ST_TERM;
            ST_TERM: state_next = ST_READ;
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = last_res ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        acc_en   = 1'b0;
        mean_en  = 1'b0;
        term_en  = 1'b0;
        rd_en    = 1'b0;
        mul_en   = 1'b0;
        out_try  = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_ACC:  acc_en = 1'b1;
            ST_MEAN: mean_en = 1'b1;
            ST_TERM: term_en = 1'b1;
            ST_READ: rd_en = 1'b1;
            ST_MUL:  mul_en = 1'b1;
            ST_OUT:  out_try = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    // control and arithmetic
    always_comb
    begin
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        j_next         = j_reg;
        have_prev_next = have_prev_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        mp_next        = mp_reg;
        tp_next        = tp_reg;
        fp_next        = fp_reg;
        out_data_next  = out_data_reg;
        out_chan_next  = out_chan_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            ch_next = rd_addr;
            if (in_ch.restart)
            begin
                have_prev_next = 1'b0;
                sum_next       = '0;
            end
        end

        if (acc_en)
        begin
            if (have_prev_reg)
            begin
                sum_next = sum_reg + SUM_W'(diff);
            end
            if (step_end)
            begin
                cnt_next       = '0;
                have_prev_next = 1'b1;
                if (!have_prev_reg)
                begin
                    sum_next = '0;
                end
            end
            else
            begin
                cnt_next = CH_W'(cnt_inc);
            end
        end

        if (mean_en)
        begin
            mp_next  = sum_reg * $signed({1'b0, cfg.recip_channel_count});
            sum_next = '0;
        end

        if (term_en)
        begin
            tp_next = mean * $signed({1'b0, cfg.mix_ratio});
            j_next  = '0;
        end

        if (mul_en)
        begin
            fp_next = WRAP_W'(fp_full);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_chan_next  = CHANNEL_W'(j_reg);
            out_last_next  = last_res;
            if (scaled > SAT_MAX)
            begin
                out_data_next = SAMPLE_W'(SAT_MAX);
            end
            else if (scaled < SAT_MIN)
            begin
                out_data_next = SAMPLE_W'(SAT_MIN);
            end
            else
            begin
                out_data_next = SAMPLE_W'(scaled);
            end
            j_next = j_reg + CH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            j_reg         <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            j_reg         <= j_next;
            have_prev_reg <= have_prev_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mp_reg       <= mp_next;
        tp_reg       <= tp_next;
        fp_reg       <= fp_next;
        out_data_reg <= out_data_next;
        out_chan_reg <= out_chan_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            sample_reg <= in_ch.sample;
        end
    end

    // previous sample store: read on accept, write back in the accumulate cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_rd_reg <= prev_mem[rd_addr];
        end
        if (acc_en)
        begin
            prev_mem[ch_reg] <= sample_reg;
        end
    end

    // difference store: written per sample, read per result
    always_ff @(posedge clk)
    begin
        if (acc_en && have_prev_reg)
        begin
            diff_mem[ch_reg] <= diff;
        end
        if (rd_en)
        begin
            diff_rd_reg <= diff_mem[j_reg];
        end
    end

    assign in_ch.ready           = in_ready;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.corrected_diff = out_data_reg;
    assign out_ch.channel        = out_chan_reg;
    assign out_ch.last           = out_last_reg;

endmodule
